[src/anchored_class_pattern_match_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the anchored class pattern matcher.
// Shared helpers that wrap concurrent assertions with a common clock and reset.
// ----------------------------------------------------------------------------
`ifndef ANCHORED_CLASS_PATTERN_MATCH_DEFINES_SVH
`define ANCHORED_CLASS_PATTERN_MATCH_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define ACPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ACPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/acpm_pkg.sv]
// ----------------------------------------------------------------------------
// acpm_pkg
// Types and character codes shared by the pattern matcher modules.
// ----------------------------------------------------------------------------
package acpm_pkg;

    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SOURCE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELEM,
        ST_ESC,
        ST_SET,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        EK_SIMPLE,
        EK_ESC,
        EK_SET
    } elem_kind_t;

    typedef struct packed {
        logic load_en;
        logic src_start;
        logic elem_eval;
        logic esc_eval;
        logic set_eval;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        elem_kind_t kind;
        logic       set_done;
        logic       src_last;
        logic       out_free;
    } dp_status_t;

endpackage

[src/acpm_ctrl.sv]
// ----------------------------------------------------------------------------
// acpm_ctrl
// Sequencer that takes pattern byte loads and steps one source transaction through
// element fetch, escape decode, set scan and result hand-off.
// ----------------------------------------------------------------------------
module acpm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   cmd,
    output logic                   in_ready,
    input  acpm_pkg::dp_status_t   status,
    output acpm_pkg::ctrl_cmd_t    ctrl
);
    import acpm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (cmd == CMD_LOAD)
                    begin
                        ctrl.load_en = 1'b1;
                    end
                    else
                    begin
                        ctrl.src_start = 1'b1;
                        state_next     = ST_ELEM;
                    end
                end
            end
            ST_ELEM:
            begin
                ctrl.elem_eval = 1'b1;
                case (status.kind)
                    EK_ESC:  state_next = ST_ESC;
                    EK_SET:  state_next = ST_SET;
                    default: state_next = status.src_last ? ST_RESULT : ST_IDLE;
                endcase
            end
            ST_ESC:
            begin
                ctrl.esc_eval = 1'b1;
                state_next    = status.src_last ? ST_RESULT : ST_IDLE;
            end
            ST_SET:
            begin
                ctrl.set_eval = 1'b1;
                if (status.set_done)
                begin
                    state_next = status.src_last ? ST_RESULT : ST_IDLE;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/acpm_dp.sv]
// ----------------------------------------------------------------------------
// acpm_dp
// Pattern store, position registers, element evaluation and output register.
// ----------------------------------------------------------------------------
`include "anchored_class_pattern_match_defines.svh"

module acpm_dp #(
    parameter int PAT_DEPTH = 128
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             byte_value,
    input  logic                   is_last,
    input  acpm_pkg::ctrl_cmd_t    ctrl,
    output acpm_pkg::dp_status_t   status,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic                   matched,
    output logic                   pattern_overflow
);
    import acpm_pkg::*;

    localparam int AW    = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
    localparam int LEN_W = $clog2(PAT_DEPTH + 1);
    localparam int POS_W = $clog2(PAT_DEPTH + 5);
    localparam logic [POS_W-1:0] POS_CAP   = POS_W'(PAT_DEPTH + 2);
    localparam logic [LEN_W-1:0] LEN_DEPTH = LEN_W'(PAT_DEPTH);

    logic [7:0]       mem [PAT_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [AW-1:0]    rd_addr;

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] load_pos_reg;
    logic [POS_W-1:0] match_pos_reg;
    logic             all_reg;
    logic             ovf_reg;
    logic [7:0]       ch_reg;
    logic             last_reg;
    logic [POS_W-1:0] k_reg;
    logic             first_reg;
    logic             neg_reg;
    logic             member_reg;
    logic             pend_reg;
    logic             out_valid_reg;
    logic             matched_reg;
    logic             ovf_out_reg;

    logic [POS_W-1:0] len_ext;
    logic [POS_W-1:0] pos_p1;
    logic [POS_W-1:0] pos_p2;
    logic [POS_W-1:0] k_p1;
    logic [POS_W-1:0] rd_pos;
    logic [7:0]       elem_byte;
    logic [7:0]       esc_byte;
    logic             k_valid;
    logic             neg_now;
    logic             set_done;
    logic             ch_upper;
    elem_kind_t       kind;
    logic             commit;
    logic             hit;
    logic [POS_W-1:0] new_pos;
    logic [POS_W-1:0] pos_sat;
    logic             all_new;
    logic             load_fits;

    assign len_ext   = POS_W'(len_reg);
    assign pos_p1    = match_pos_reg + POS_W'(1);
    assign pos_p2    = match_pos_reg + POS_W'(2);
    assign k_p1      = k_reg + POS_W'(1);
    assign load_fits = (load_pos_reg < LEN_DEPTH);
    assign ch_upper  = (ch_reg >= CH_UPPER_A) && (ch_reg <= CH_UPPER_Z);

    assign elem_byte = (match_pos_reg < len_ext) ? rd_data_reg : 8'h00;
    assign esc_byte  = (pos_p1 < len_ext) ? rd_data_reg : 8'h00;
    assign k_valid   = (k_reg < len_ext);
    assign neg_now   = first_reg ? (k_valid && (rd_data_reg == CH_CARET)) : neg_reg;
    assign set_done  = !(k_valid && (rd_data_reg != CH_RBRACKET));

    always_comb
    begin
        case (elem_byte)
            CH_LBRACKET:  kind = EK_SET;
            CH_BACKSLASH: kind = EK_ESC;
            default:      kind = EK_SIMPLE;
        endcase
    end

    always_comb
    begin
        rd_pos = match_pos_reg;
        if (ctrl.elem_eval && (kind != EK_SIMPLE))
        begin
            rd_pos = pos_p1;
        end
        else if (ctrl.set_eval)
        begin
            rd_pos = k_p1;
        end
    end
    assign rd_addr = rd_pos[AW-1:0];

    always_comb
    begin
        commit  = 1'b0;
        hit     = 1'b0;
        new_pos = pos_p1;
        if (ctrl.elem_eval && (kind == EK_SIMPLE))
        begin
            commit  = 1'b1;
            hit     = (elem_byte == CH_DOT) || (elem_byte == ch_reg);
            new_pos = pos_p1;
        end
        else if (ctrl.esc_eval)
        begin
            commit  = 1'b1;
            new_pos = pos_p2;
            if (esc_byte == CH_LOWER_A)
            begin
                hit = !ch_upper;
            end
            else if (esc_byte == CH_UPPER_A)
            begin
                hit = ch_upper;
            end
        end
        else if (ctrl.set_eval && set_done)
        begin
            commit  = 1'b1;
            hit     = neg_now ? !member_reg : member_reg;
            new_pos = k_p1;
        end
    end

    assign pos_sat = (new_pos > POS_CAP) ? POS_CAP : new_pos;
    assign all_new = all_reg && hit;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_en && load_fits)
        begin
            mem[load_pos_reg[AW-1:0]] <= byte_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.src_start)
        begin
            ch_reg   <= byte_value;
            last_reg <= is_last;
        end
        if (ctrl.elem_eval)
        begin
            k_reg      <= pos_p1;
            first_reg  <= 1'b1;
            member_reg <= 1'b0;
        end
        else if (ctrl.set_eval)
        begin
            first_reg <= 1'b0;
            neg_reg   <= neg_now;
            if (!set_done)
            begin
                k_reg      <= k_p1;
                member_reg <= member_reg || (rd_data_reg == ch_reg);
            end
        end
        if (commit && last_reg)
        begin
            pend_reg <= all_new && (pos_sat == len_ext);
        end
        if (ctrl.out_load)
        begin
            matched_reg <= pend_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            load_pos_reg  <= '0;
            match_pos_reg <= '0;
            all_reg       <= 1'b1;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load_en)
            begin
                if (load_fits)
                begin
                    len_reg <= load_pos_reg + LEN_W'(1);
                    if (load_pos_reg == '0)
                    begin
                        ovf_reg <= 1'b0;
                    end
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                if (is_last)
                begin
                    load_pos_reg <= '0;
                end
                else if (load_fits)
                begin
                    load_pos_reg <= load_pos_reg + LEN_W'(1);
                end
                match_pos_reg <= '0;
                all_reg       <= 1'b1;
            end
            else if (commit)
            begin
                if (last_reg)
                begin
                    match_pos_reg <= '0;
                    all_reg       <= 1'b1;
                end
                else
                begin
                    match_pos_reg <= pos_sat;
                    all_reg       <= all_new;
                end
            end
            if (ctrl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.kind     = kind;
    assign status.set_done = set_done;
    assign status.src_last = last_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = ovf_out_reg;

    `ACPM_ASSERT_NOW(a_pos_cap, clk, rst_n, 1'b1,
                     match_pos_reg <= POS_CAP, "match position above cap")
    `ACPM_ASSERT_NOW(a_len_bound, clk, rst_n, 1'b1,
                     (len_reg <= LEN_DEPTH) && (load_pos_reg <= LEN_DEPTH),
                     "pattern length beyond store")
    `ACPM_ASSERT_NEXT(a_load_rewind, clk, rst_n, ctrl.load_en,
                      (match_pos_reg == '0) && all_reg, "load did not rewind match state")
    `ACPM_ASSERT_NOW(a_out_load_free, clk, rst_n, ctrl.out_load,
                     !out_valid_reg || out_ready, "result overwrote a pending transaction")

endmodule

[src/anchored_class_pattern_match.sv]
// Sequence: a pattern byte is taken in the idle state; a source character goes through element
// evaluation, then escape decode for an escape or a set scan (one store read per set byte).
// A final source character adds a result hand-off state; the result register is valid next.
// Throughput: one transaction at a time, bounded by the single store read port.
// Reset clears control and position state; the pattern store is not cleared.
// ----------------------------------------------------------------------------
// anchored_class_pattern_match
// Anchored pattern matcher with classes, negated sets and case escapes.
// ----------------------------------------------------------------------------
module anchored_class_pattern_match #(
    parameter int PAT_DEPTH = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] byte_value,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       matched,
    output logic       pattern_overflow
);
    import acpm_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    acpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .in_ready (in_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    acpm_dp #(
        .PAT_DEPTH (PAT_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_value       (byte_value),
        .is_last          (is_last),
        .ctrl             (ctrl),
        .status           (status),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .matched          (matched),
        .pattern_overflow (pattern_overflow)
    );

endmodule

[sim/anchored_class_pattern_match_test.sv]
// ----------------------------------------------------------------------------
// anchored_class_pattern_match_test
// Self-checking testbench for the anchored pattern matcher. A short table of
// pattern loads and source characters covers the element kinds and the corner
// cases. Random patterns follow, each with sources built to match them and
// then mutated, plus noise transactions. Every result is compared with a
// behavioral model of the matcher or a table entry while both handshakes idle and stall.
// ----------------------------------------------------------------------------
module anchored_class_pattern_match_test;
    timeunit 1ns;
    timeprecision 1ps;

    import acpm_pkg::*;

    localparam int DEPTH         = 128;
    localparam int N_ITEMS       = 500;
    localparam int DRAIN_CYCLES  = 200;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int N_DIR         = 28;

    typedef logic [7:0] char_t;

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    typedef struct packed {
        logic  c;
        char_t v;
        logic  last;
        logic  typed;
        logic  want_m;
        logic  want_o;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       cmd;
    logic [7:0] byte_value;
    logic       is_last;
    logic       out_valid;
    logic       out_ready;
    logic       matched;
    logic       pattern_overflow;

    char_t       pat_mem [DEPTH];
    int unsigned pat_len;
    int unsigned load_pos;
    int unsigned match_pos;
    bit          all_ok;
    bit          ovf_seen;

    verdict_t    verdict_q [$];
    verdict_t    front_v;
    int          errors = 0;
    int          items_sent;
    int          n_verdicts;
    int          cycles = 0;
    bit          calm;

    // Sources without a pattern, byte extremes, a negated set holding only the
    // caret, both case escapes, an abandoned source, a missing close bracket,
    // an escape of another byte and the empty set.
    dir_row_t dir_rows [N_DIR] = '{
        '{CMD_SOURCE, "x",          1'b1, 1'b1, 1'b0, 1'b0},
        '{CMD_LOAD,   8'h00,        1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD,   8'hFF,        1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_SOURCE, 8'h00,        1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_SOURCE, 8'hFF,        1'b1, 1'b1, 1'b1, 1'b0},
        '{CMD_LOAD,   CH_LBRACKET,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD,   CH_CARET,     1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD,   CH_RBRACKET,  1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_SOURCE, CH_CARET,     1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_SOURCE, "z",          1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD,   CH_DOT,       1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD,   CH_BACKSLASH, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD,   CH_LOWER_A,   1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD,   CH_BACKSLASH, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD,   CH_UPPER_A,   1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_SOURCE, 8'h80,        1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_SOURCE, "q",          1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_SOURCE, CH_UPPER_Z,   1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_SOURCE, "1",          1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD,   CH_LBRACKET,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD,   "x",          1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_SOURCE, "x",          1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD,   CH_BACKSLASH, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD,   "z",          1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_SOURCE, "a",          1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD,   CH_LBRACKET,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_LOAD,   CH_RBRACKET,  1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_SOURCE, "a",          1'b1, 1'b1, 1'b0, 1'b0}
    };

    anchored_class_pattern_match #(
        .PAT_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .byte_value(byte_value),
        .is_last(is_last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .matched(matched),
        .pattern_overflow(pattern_overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic char_t elem_at(int unsigned i);
        return (i < pat_len && i < DEPTH) ? pat_mem[i] : 8'h00;
    endfunction

    // Advances the matcher state by one transaction and returns 1 when that
    // transaction produces a result.
    function automatic bit step_matcher(input logic c, input char_t ch, input logic last,
                                        output verdict_t v);
        int unsigned p;
        int unsigned k;
        int unsigned n;
        int unsigned adv;
        char_t       e;
        char_t       nx;
        bit          hit;
        bit          member;
        bit          neg;
        v = '0;
        if (c == CMD_LOAD)
        begin
            if (load_pos == 0)
            begin
                pat_len = 0;
                ovf_seen = 1'b0;
            end
            if (load_pos < DEPTH)
            begin
                pat_mem[load_pos] = ch;
                load_pos++;
                pat_len = load_pos;
            end
            else
            begin
                ovf_seen = 1'b1;
            end
            if (last)
                load_pos = 0;
            match_pos = 0;
            all_ok = 1'b1;
            return 1'b0;
        end
        p = match_pos;
        e = elem_at(p);
        hit = 1'b0;
        adv = 1;
        case (e)
            CH_DOT:
            begin
                hit = 1'b1;
            end
            CH_LBRACKET:
            begin
                k = p + 1;
                n = 0;
                member = 1'b0;
                neg = (k < pat_len) && (elem_at(k) == CH_CARET);
                while (k < pat_len && elem_at(k) != CH_RBRACKET)
                begin
                    if (elem_at(k) == ch)
                        member = 1'b1;
                    k++;
                    n++;
                end
                hit = neg ? !member : member;
                adv = n + 2;
            end
            CH_BACKSLASH:
            begin
                nx = elem_at(p + 1);
                if (nx == CH_LOWER_A)
                    hit = !(ch >= CH_UPPER_A && ch <= CH_UPPER_Z);
                else if (nx == CH_UPPER_A)
                    hit = (ch >= CH_UPPER_A && ch <= CH_UPPER_Z);
                adv = 2;
            end
            default:
            begin
                hit = (e == ch);
            end
        endcase
        if (!hit)
            all_ok = 1'b0;
        match_pos = (p + adv > DEPTH + 2) ? DEPTH + 2 : p + adv;
        if (!last)
            return 1'b0;
        v.matched = all_ok && (match_pos == pat_len);
        v.overflow = ovf_seen;
        match_pos = 0;
        all_ok = 1'b1;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic drive_item(input logic c, input char_t v, input logic last,
                              input bit typed, input verdict_t typed_v);
        verdict_t pv;
        int       gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        byte_value <= v;
        is_last <= last;
        if (step_matcher(c, v, last, pv))
        begin
            verdict_q.push_back(typed ? typed_v : pv);
            n_verdicts++;
        end
        items_sent++;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_run(input logic c, input char_t bytes [$]);
        foreach (bytes[i])
            drive_item(c, bytes[i], i == bytes.size() - 1, 1'b0, '0);
    endtask

    // Builds a pattern, well-formed but that a final set may lack its close bracket,
    // and, for each element, one character that the element accepts where one exists.
    task automatic build_pattern(output char_t pat [$], output char_t good [$]);
        int    n_elem;
        int    kind;
        int    n_set;
        bit    neg;
        bit    hit;
        char_t c;
        char_t set_m [$];
        pat = {};
        good = {};
        n_elem = $urandom_range(1, 8);
        for (int e = 0; e < n_elem; e++)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 3)
            begin
                do c = char_t'($urandom);
                while (c == CH_DOT || c == CH_LBRACKET || c == CH_BACKSLASH);
                pat.push_back(c);
                good.push_back(c);
            end
            else if (kind == 4)
            begin
                pat.push_back(CH_DOT);
                good.push_back(char_t'($urandom));
            end
            else if (kind == 5)
            begin
                pat.push_back(CH_BACKSLASH);
                pat.push_back(CH_LOWER_A);
                do c = char_t'($urandom);
                while (c >= CH_UPPER_A && c <= CH_UPPER_Z);
                good.push_back(c);
            end
            else if (kind == 6)
            begin
                pat.push_back(CH_BACKSLASH);
                pat.push_back(CH_UPPER_A);
                good.push_back(char_t'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
            end
            else if (kind == 7)
            begin
                do c = char_t'($urandom);
                while (c == CH_LOWER_A || c == CH_UPPER_A);
                pat.push_back(CH_BACKSLASH);
                pat.push_back(c);
                good.push_back(char_t'($urandom));
            end
            else
            begin
                neg = ($urandom_range(0, 2) == 0);
                n_set = $urandom_range(0, 4);
                set_m = {};
                pat.push_back(CH_LBRACKET);
                if (neg)
                begin
                    pat.push_back(CH_CARET);
                    set_m.push_back(CH_CARET);
                end
                for (int i = 0; i < n_set; i++)
                begin
                    do c = char_t'($urandom);
                    while (c == CH_RBRACKET || (!neg && i == 0 && c == CH_CARET));
                    pat.push_back(c);
                    set_m.push_back(c);
                end
                if (e != n_elem - 1 || $urandom_range(0, 9) != 0)
                    pat.push_back(CH_RBRACKET);
                if (neg)
                begin
                    do
                    begin
                        c = char_t'($urandom);
                        hit = 1'b0;
                        foreach (set_m[i])
                            if (set_m[i] == c)
                                hit = 1'b1;
                    end
                    while (hit);
                    good.push_back(c);
                end
                else if (n_set > 0)
                begin
                    good.push_back(set_m[$urandom_range(0, n_set - 1)]);
                end
                else
                begin
                    good.push_back(char_t'($urandom));
                end
            end
        end
    endtask

    initial
    begin
        int    cyc;
        cyc = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (cyc > 0)
            begin
                out_ready <= 1'b0;
                cyc--;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                cyc = pick_gap();
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected result matched=%0b pattern_overflow=%0b",
                         $time, matched, pattern_overflow);
                errors++;
            end
            else
            begin
                front_v = verdict_q.pop_front();
                if (matched !== front_v.matched)
                begin
                    $display("%0t: matched expected %0b actual %0b",
                             $time, front_v.matched, matched);
                    errors++;
                end
                if (pattern_overflow !== front_v.overflow)
                begin
                    $display("%0t: pattern_overflow expected %0b actual %0b",
                             $time, front_v.overflow, pattern_overflow);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        char_t pat [$];
        char_t good [$];
        char_t src [$];
        int    seq;
        int    r;
        bit    long_src;
        items_sent = 0;
        n_verdicts = 0;
        calm = 1'b0;
        pat_len = 0;
        load_pos = 0;
        match_pos = 0;
        all_ok = 1'b1;
        ovf_seen = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        cmd <= CMD_LOAD;
        byte_value <= 8'h00;
        is_last <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            drive_item(dir_rows[i].c, dir_rows[i].v, dir_rows[i].last, dir_rows[i].typed,
                       verdict_t'{dir_rows[i].want_m, dir_rows[i].want_o});

        seq = 0;
        while (items_sent < N_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if (seq == 7)
            begin
                // A pattern longer than the store, so its tail is dropped.
                pat = {};
                repeat (DEPTH + $urandom_range(1, 6))
                    pat.push_back($urandom_range(0, 1) ? CH_DOT : char_t'($urandom));
                send_run(CMD_LOAD, pat);
                src = {};
                repeat ($urandom_range(1, 4))
                    src.push_back(char_t'($urandom));
                send_run(CMD_SOURCE, src);
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    drive_item(logic'($urandom_range(0, 1)), char_t'($urandom),
                               $urandom_range(0, 3) == 0, 1'b0, '0);
            end
            else
            begin
                build_pattern(pat, good);
                send_run(CMD_LOAD, pat);
                long_src = (seq == 15);
                repeat ($urandom_range(1, 3))
                begin
                    src = good;
                    foreach (src[i])
                        if ($urandom_range(0, 11) == 0)
                            src[i] = char_t'($urandom);
                    r = $urandom_range(0, 9);
                    if (r == 0 && src.size() > 1)
                        void'(src.pop_back());
                    else if (r == 1)
                        src.push_back($urandom_range(0, 1) ? 8'h00 : char_t'($urandom));
                    if (long_src)
                    begin
                        repeat (DEPTH + 5)
                            src.push_back(char_t'($urandom));
                        long_src = 1'b0;
                    end
                    send_run(CMD_SOURCE, src);
                end
            end
            seq++;
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[anchored_class_pattern_match.f]
+incdir+src
src/acpm_pkg.sv
src/acpm_ctrl.sv
src/acpm_dp.sv
src/anchored_class_pattern_match.sv
sim/anchored_class_pattern_match_test.sv
